// ===== sv/tptq_pkg.sv =====
// Package for the timed priority task queue: sizes, codes and the ordering rule.
// No dependencies; used by every module of the block by scoped names.
package tptq_pkg;
  localparam int unsigned NumTasks = 16;
  localparam int unsigned IdBits   = 4;
  localparam int unsigned CntBits  = 5;
  localparam int unsigned TimeBits = 32;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdBits-1:0]   id_t;

  typedef enum logic [1:0] {
    ACT_SCHED  = 2'd0,
    ACT_PAUSE  = 2'd1,
    ACT_RESUME = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PLACE_NONE    = 2'd0,
    PLACE_PENDING = 2'd1,
    PLACE_READY   = 2'd2
  } place_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_ALREADY = 3'd2,
    ST_PENDING = 3'd3,
    ST_WAITING = 3'd4,
    ST_FIRED   = 3'd5
  } status_e;

  // Key carried by a list entry or by the task being inserted.
  typedef struct packed {
    time_t       due;
    logic [15:0] prio;
    logic [30:0] run;
  } key_t;

  // Command broadcast to the list cells, each gated by the walk position.
  typedef struct packed {
    logic shift_in;  // insert walk: hand the carried entry one place down
    logic shift_out; // removal walk: take the entry from the cell below
  } cell_cmd_t;

  function automatic logic later_than(time_t a, time_t b);
    time_t d;
    d = a - b;
    return (d != '0) && !d[TimeBits-1];
  endfunction

  // True when new task a goes before list entry b.
  function automatic logic ranks_above(key_t a, key_t b);
    logic res;
    if (a.due == b.due) begin
      res = $signed(a.prio) > $signed(b.prio);
    end else if (later_than(a.due, b.due)) begin
      res = !($signed(b.prio) >= $signed(a.prio) ||
              later_than(a.due, b.due + time_t'(b.run)));
    end else begin
      res = ($signed(a.prio) >= $signed(b.prio)) ||
            later_than(b.due, a.due + time_t'(a.run));
    end
    return res;
  endfunction
endpackage

// ===== sv/tptq_cell.sv =====
// One place of the ordered ready list: holds a slot number and hands it on.
// Depends on tptq_pkg.
module tptq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tptq_pkg::cell_cmd_t cmd_i,
  input  logic               sel_i,   // this cell is the one acted on
  input  tptq_pkg::id_t      up_i,    // entry of the cell above
  input  tptq_pkg::id_t      down_i,  // entry of the cell below
  input  tptq_pkg::id_t      new_i,   // entry being placed
  output tptq_pkg::id_t      id_o
);
  tptq_pkg::id_t id_q, id_d;

  always_comb begin
    id_d = id_q;
    if (cmd_i.shift_in) begin
      if (sel_i) id_d = new_i;
      else       id_d = up_i;
    end else if (cmd_i.shift_out) begin
      id_d = down_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) id_q <= '0;
    else         id_q <= id_d;
  end

  assign id_o = id_q;
endmodule

// ===== sv/timed_priority_task_queue_unit.sv =====
// Timed priority task queue: sixteen task slots and an ordered ready list.
// Flow: capture, decide, any list walk, then a done state; the result strobe is registered
// from the done state. An insert or removal walk compares list entries one by one, and a
// fired periodic tick runs a removal walk followed by an insert walk.
// The next transaction is taken in the strobe cycle, not before the last one is through.
// Reset: all slots none, list empty; result strobe low. Receiver cannot stall.
module timed_priority_task_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  task_id_i,
  input  logic [31:0] delay_i,
  input  logic [15:0] prio_i,
  input  logic [30:0] run_length_i,
  input  logic [30:0] period_i,
  input  logic [31:0] now_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  fired_task_o,
  output logic [30:0] wait_ticks_o,
  output logic        queue_empty_o
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_INSWLK = 5'b00100,
    S_REMWLK = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Slot storage.
  tptq_pkg::time_t  due_q   [tptq_pkg::NumTasks];
  logic [15:0]      prio_q  [tptq_pkg::NumTasks];
  logic [30:0]      run_q   [tptq_pkg::NumTasks];
  logic [30:0]      per_q   [tptq_pkg::NumTasks];
  tptq_pkg::place_e place_q [tptq_pkg::NumTasks];
  logic [tptq_pkg::CntBits-1:0] cnt_q;

  // Captured transaction.
  logic [1:0]       act_q;
  tptq_pkg::id_t    id_q;
  logic [31:0]      delay_q, now_q;
  logic [15:0]      prio_in_q;
  logic [30:0]      run_in_q, per_in_q;

  // Walk position and result registers.
  logic [tptq_pkg::CntBits-1:0] pos_q;
  tptq_pkg::id_t    tgt_q;    // slot being inserted or removed
  logic [2:0]       status_q;
  tptq_pkg::id_t    fired_q;
  logic [30:0]      wait_q;

  // List cells.
  tptq_pkg::id_t    ids [tptq_pkg::NumTasks];
  tptq_pkg::cell_cmd_t cmd;
  logic [tptq_pkg::NumTasks-1:0] sel;
  logic [tptq_pkg::IdBits-1:0] pos_idx;

  assign pos_idx = pos_q[tptq_pkg::IdBits-1:0];

  for (genvar g = 0; g < tptq_pkg::NumTasks; g++) begin : g_cell
    tptq_pkg::id_t up_w, dn_w;
    if (g == 0) begin : g_top
      assign up_w = ids[0];
    end else begin : g_mid
      assign up_w = ids[g-1];
    end
    if (g == tptq_pkg::NumTasks - 1) begin : g_bot
      assign dn_w = ids[g];
    end else begin : g_nbot
      assign dn_w = ids[g+1];
    end
    // Insert: cells at and below pos take the one above; pos takes new.
    // Remove: cells at and below pos take the one below.
    tptq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (tptq_pkg::cell_cmd_t'{shift_in:  cmd.shift_in  && (g >= pos_q),
                                     shift_out: cmd.shift_out && (g >= pos_q)}),
      .sel_i  (sel[g]),
      .up_i   (up_w),
      .down_i (dn_w),
      .new_i  (tgt_q),
      .id_o   (ids[g])
    );
  end

  always_comb begin
    for (int i = 0; i < tptq_pkg::NumTasks; i++) sel[i] = (pos_q == i);
  end

  // Comparison of the carried task against the list entry at pos.
  tptq_pkg::key_t key_a, key_b;
  tptq_pkg::id_t  cur_id;
  logic           above, at_end, match;
  assign cur_id = ids[pos_idx];
  assign key_a  = '{due: due_q[tgt_q], prio: prio_q[tgt_q], run: run_q[tgt_q]};
  assign key_b  = '{due: due_q[cur_id], prio: prio_q[cur_id], run: run_q[cur_id]};
  assign above  = tptq_pkg::ranks_above(key_a, key_b);
  assign at_end = (pos_q >= cnt_q);
  assign match  = (cur_id == tgt_q);

  // Head due check for tick: head_wait is high while the head is not yet due.
  tptq_pkg::id_t   head;
  tptq_pkg::time_t head_diff;
  logic            head_wait;
  assign head      = ids[0];
  assign head_diff = due_q[head] - now_q;
  assign head_wait = !head_diff[tptq_pkg::TimeBits-1] && (head_diff != '0);

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_DECIDE;
      S_DECIDE: begin
        // Pick the list walk, if any, that the transaction needs.
        state_d = S_DONE;
        priority if (act_q == tptq_pkg::ACT_TICK) begin
          if (cnt_q != '0 && !head_wait) state_d = S_REMWLK;
        end else if (act_q == tptq_pkg::ACT_SCHED) begin
          if (!delay_q[31] && place_q[id_q] == tptq_pkg::PLACE_NONE) state_d = S_INSWLK;
        end else if (act_q == tptq_pkg::ACT_PAUSE) begin
          if (place_q[id_q] == tptq_pkg::PLACE_READY) state_d = S_REMWLK;
        end else begin
          if (place_q[id_q] == tptq_pkg::PLACE_PENDING && per_q[id_q] != '0) begin
            state_d = S_INSWLK;
          end
        end
      end
      S_INSWLK: begin
        // Place before the first entry the task ranks above, else at the tail.
        if (at_end || above) begin
          cmd.shift_in = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_REMWLK: begin
        if (at_end || match) begin
          // An entry already past the new tail needs no shift.
          cmd.shift_out = !at_end;
          // Periodic fired task goes back into the list.
          state_d = (act_q == tptq_pkg::ACT_TICK && per_q[tgt_q] != '0) ? S_INSWLK : S_DONE;
        end
      end
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      tgt_q   <= '0;
      for (int i = 0; i < tptq_pkg::NumTasks; i++) begin
        due_q[i]   <= '0;
        prio_q[i]  <= '0;
        run_q[i]   <= '0;
        per_q[i]   <= '0;
        place_q[i] <= tptq_pkg::PLACE_NONE;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_DECIDE: begin
          // Update the slot; the next-state logic starts the matching walk.
          priority if (act_q == tptq_pkg::ACT_TICK) begin
            if (cnt_q != '0 && !head_wait) begin
              place_q[head] <= tptq_pkg::PLACE_NONE;
              tgt_q <= head;
              pos_q <= '0;
              cnt_q <= cnt_q - 1'b1;
              if (per_q[head] != '0) begin
                due_q[head] <= due_q[head] + tptq_pkg::time_t'(per_q[head]);
              end
            end
          end else if (act_q == tptq_pkg::ACT_SCHED) begin
            if (!delay_q[31] && place_q[id_q] != tptq_pkg::PLACE_READY) begin
              prio_q[id_q] <= prio_in_q;
              run_q[id_q]  <= run_in_q;
              per_q[id_q]  <= per_in_q;
              due_q[id_q]  <= now_q + delay_q;
              if (place_q[id_q] == tptq_pkg::PLACE_NONE) begin
                tgt_q <= id_q; pos_q <= '0;
                place_q[id_q] <= tptq_pkg::PLACE_READY;
              end
            end
          end else if (act_q == tptq_pkg::ACT_PAUSE) begin
            if (place_q[id_q] != tptq_pkg::PLACE_PENDING) begin
              place_q[id_q] <= tptq_pkg::PLACE_PENDING;
              if (place_q[id_q] == tptq_pkg::PLACE_READY) begin
                tgt_q <= id_q; pos_q <= '0;
                cnt_q <= cnt_q - 1'b1;
              end
            end
          end else begin
            if (place_q[id_q] == tptq_pkg::PLACE_PENDING) begin
              if (per_q[id_q] != '0) begin
                tgt_q <= id_q; pos_q <= '0;
                place_q[id_q] <= tptq_pkg::PLACE_READY;
              end else begin
                place_q[id_q] <= tptq_pkg::PLACE_NONE;
              end
            end
          end
        end
        S_INSWLK: begin
          if (at_end || above) cnt_q <= cnt_q + 1'b1;
          else                 pos_q <= pos_q + 1'b1;
        end
        S_REMWLK: begin
          if (!at_end && !match) pos_q <= pos_q + 1'b1;
          // Periodic fired task goes back into the list.
          else if (act_q == tptq_pkg::ACT_TICK && per_q[tgt_q] != '0) begin
            place_q[tgt_q] <= tptq_pkg::PLACE_READY;
            pos_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Removal walks against the count already dropped at decide: when the
  // target sits at that position it is past the new tail and is simply left.

  // Capture and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      act_q     <= action_i;
      id_q      <= task_id_i;
      delay_q   <= delay_i;
      prio_in_q <= prio_i;
      run_in_q  <= run_length_i;
      per_in_q  <= period_i;
      now_q     <= now_i;
    end
    if (state_q == S_DECIDE) begin
      status_q <= tptq_pkg::ST_OK;
      fired_q  <= '0;
      wait_q   <= '0;
      priority if (act_q == tptq_pkg::ACT_TICK) begin
        if (cnt_q != '0) begin
          if (head_wait) begin
            status_q <= tptq_pkg::ST_WAITING;
            wait_q   <= head_diff[30:0];
          end else begin
            status_q <= tptq_pkg::ST_FIRED;
            fired_q  <= head;
          end
        end
      end else if (act_q == tptq_pkg::ACT_SCHED) begin
        if (delay_q[31])                                 status_q <= tptq_pkg::ST_INVALID;
        else if (place_q[id_q] == tptq_pkg::PLACE_READY)   status_q <= tptq_pkg::ST_ALREADY;
        else if (place_q[id_q] == tptq_pkg::PLACE_PENDING) status_q <= tptq_pkg::ST_PENDING;
      end else if (act_q == tptq_pkg::ACT_PAUSE) begin
        if (place_q[id_q] == tptq_pkg::PLACE_PENDING) status_q <= tptq_pkg::ST_ALREADY;
      end else begin
        if (place_q[id_q] != tptq_pkg::PLACE_PENDING) status_q <= tptq_pkg::ST_INVALID;
      end
    end
  end

  assign status_o      = status_q;
  assign fired_task_o  = fired_q;
  assign wait_ticks_o  = wait_q;
  assign queue_empty_o = (cnt_q == '0);
endmodule
